>>> hdl/tspt_pkg.sv
`timescale 1ns / 1ps

package tspt_pkg;

	// Field and register widths
	localparam int ANGLE_W    = 32;  // internal angle precision (saturation range)
	localparam int OUT_W      = 32;  // angle result fields
	localparam int DELTA_W    = 24;
	localparam int GAIN_W     = 8;
	localparam int STEP_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int AXES       = 3;

	// Scaled turn delta: signed delta times unsigned gain
	localparam int SCALED_W = DELTA_W + GAIN_W + 1;
	// Travelled count plus one step
	localparam int CNT_W    = ANGLE_W + 1;
	// Wide enough for every pre-saturation sum
	localparam int WIDE_W   = ((ANGLE_W + 3) > (SCALED_W + 2)) ? (ANGLE_W + 3) : (SCALED_W + 2);

	// Operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_TURN = 1'b1;

	// Axis codes
	localparam logic [1:0] AXIS_BOTTOM   = 2'd0;
	localparam logic [1:0] AXIS_SIDE     = 2'd1;
	localparam logic [1:0] AXIS_VERTICAL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_BOTTOM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIDE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_VERTICAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_GAIN   = 2'd3;

	// Register reset values
	localparam logic [STEP_W-1:0] STEP_BOTTOM_RST   = 16'd144;
	localparam logic [STEP_W-1:0] STEP_SIDE_RST     = 16'd9;
	localparam logic [STEP_W-1:0] STEP_VERTICAL_RST = 16'd288;
	localparam logic [GAIN_W-1:0] BOTTOM_GAIN_RST   = 8'd10;

	// Per-axis command for one word
	typedef struct packed {
		logic turn;
		logic tick;
	} axis_cmd_t;

	// Per-axis status after one word
	typedef struct packed {
		logic started;
		logic moving;
		logic dir;
	} axis_stat_t;

	// Clamp a wide signed sum to the signed angle range
	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat_angle = hi[ANGLE_W-1:0];
		end else if (v < lo) begin
			sat_angle = lo[ANGLE_W-1:0];
		end else begin
			sat_angle = v[ANGLE_W-1:0];
		end
	endfunction

	// Low result bits of an angle, sign extended first
	function automatic logic [OUT_W-1:0] angle_out(input logic signed [ANGLE_W-1:0] a);
		logic signed [WIDE_W-1:0] ext;
		ext = WIDE_W'(a);
		angle_out = ext[OUT_W-1:0];
	endfunction

endpackage

>>> hdl/tspt_axis.sv
`timescale 1ns / 1ps

module tspt_axis (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tspt_pkg::axis_cmd_t                    cmd,
	input  logic signed [tspt_pkg::SCALED_W-1:0]   delta,
	input  logic        [tspt_pkg::STEP_W-1:0]     step,
	output tspt_pkg::axis_stat_t                   stat,
	output logic signed [tspt_pkg::ANGLE_W-1:0]    present
);
	import tspt_pkg::*;

	logic signed [ANGLE_W-1:0] target_q, present_q;
	logic        [ANGLE_W-1:0] remain_q, count_q;
	logic                      dir_q, moving_q, changed_q;

	logic        [CNT_W-1:0]   cnt_sum;
	logic signed [WIDE_W-1:0]  cnt_wide, moved, target_sum;
	logic                      tick_end, attempt, far, start, neg;
	logic signed [ANGLE_W-1:0] tgt_nxt, pres_nxt;
	logic signed [ANGLE_W:0]   diff, st, mag;

	// Step counting and end of move
	assign cnt_sum  = {1'b0, count_q} + CNT_W'(step);
	assign tick_end = cmd.tick && moving_q && ((cnt_sum > {1'b0, remain_q}) || changed_q);
	assign cnt_wide = signed'(WIDE_W'(cnt_sum));
	assign moved    = dir_q ? (WIDE_W'(present_q) - cnt_wide) : (WIDE_W'(present_q) + cnt_wide);

	// Target and present after this word
	assign target_sum = WIDE_W'(target_q) + WIDE_W'(delta);
	assign tgt_nxt    = cmd.turn ? sat_angle(target_sum) : target_q;
	assign pres_nxt   = tick_end ? sat_angle(moved) : present_q;

	// Start check: more than one step away
	assign attempt = (cmd.turn && !moving_q) || tick_end;
	assign diff    = (ANGLE_W + 1)'(tgt_nxt) - (ANGLE_W + 1)'(pres_nxt);
	assign st      = signed'((ANGLE_W + 1)'(step));
	assign far     = (diff > st) || (diff < -st);
	assign start   = attempt && far;
	assign neg     = diff[ANGLE_W];
	assign mag     = neg ? -diff : diff;

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			present_q <= '0;
			remain_q  <= '0;
			count_q   <= '0;
			dir_q     <= 1'b0;
			moving_q  <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			target_q  <= tgt_nxt;
			present_q <= pres_nxt;
			if (start) begin
				dir_q    <= neg;
				remain_q <= mag[ANGLE_W-1:0];
			end
			if (start || tick_end) begin
				count_q <= '0;
			end else if (cmd.tick && moving_q) begin
				count_q <= cnt_sum[ANGLE_W-1:0];
			end
			if (start) begin
				moving_q <= 1'b1;
			end else if (tick_end) begin
				moving_q <= 1'b0;
			end
			if (start) begin
				changed_q <= 1'b0;
			end else if (cmd.turn || tick_end) begin
				changed_q <= 1'b1;
			end
		end
	end

	// Status as it stands after this word
	assign stat.started = start && cmd.turn;
	assign stat.moving  = start ? 1'b1 : (tick_end ? 1'b0 : moving_q);
	assign stat.dir     = start ? neg : dir_q;
	assign present      = pres_nxt;

endmodule

>>> hdl/three_axis_stepper_position_tracker.sv
`timescale 1ns / 1ps

// Channel  Handshake                Word
// in       in_valid / in_stall      op, axis_sel, angle_delta
// out      out_valid / out_stall    move_started, busy_mask, dir_mask, angle_bottom,
//                                   angle_side, angle_vertical
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word per cycle while in_stall is low.
// The bottom gain multiply sits ahead of the input register; axis updates sit between
// the input register and the result register.
// arst_n clears all angles, moves and marks and loads the register reset values.
// An input word is taken while a result waits, as long as the result register can
// drain; in_stall rises only while a result is held and the input register is full.

module three_axis_stepper_position_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [1:0]                           axis_sel,
	input  logic signed [tspt_pkg::DELTA_W-1:0]  angle_delta,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 move_started,
	output logic [tspt_pkg::AXES-1:0]            busy_mask,
	output logic [tspt_pkg::AXES-1:0]            dir_mask,
	output logic signed [tspt_pkg::OUT_W-1:0]    angle_bottom,
	output logic signed [tspt_pkg::OUT_W-1:0]    angle_side,
	output logic signed [tspt_pkg::OUT_W-1:0]    angle_vertical,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tspt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tspt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tspt_pkg::*;

	logic [STEP_W-1:0] step_bottom_q, step_side_q, step_vert_q;
	logic [GAIN_W-1:0] gain_q;

	logic                       valid_s1, op_s1;
	logic [1:0]                 axis_s1;
	logic signed [SCALED_W-1:0] delta_s1;
	logic signed [SCALED_W-1:0] scaled, delta_ext;

	logic       out_free, fire;
	axis_cmd_t  cmd   [AXES];
	axis_stat_t stat  [AXES];
	logic signed [ANGLE_W-1:0] present [AXES];

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_bottom_q <= STEP_BOTTOM_RST;
			step_side_q   <= STEP_SIDE_RST;
			step_vert_q   <= STEP_VERTICAL_RST;
			gain_q        <= BOTTOM_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_BOTTOM:   step_bottom_q <= cfg_data;
				REG_STEP_SIDE:     step_side_q   <= cfg_data;
				REG_STEP_VERTICAL: step_vert_q   <= cfg_data;
				REG_BOTTOM_GAIN:   gain_q        <= cfg_data[GAIN_W-1:0];
			endcase
		end
	end

	// Flow control
	assign out_free = !out_valid || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Bottom deltas are scaled on the way in
	assign delta_ext = SCALED_W'(angle_delta);
	assign scaled    = (axis_sel == AXIS_BOTTOM)
		? (delta_ext * SCALED_W'($signed({1'b0, gain_q}))) : delta_ext;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= op;
			axis_s1  <= axis_sel;
			delta_s1 <= scaled;
		end
	end

	// Axis units
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic [STEP_W-1:0] step_sel;

		assign step_sel = (a == 0) ? step_bottom_q : ((a == 1) ? step_side_q : step_vert_q);
		assign cmd[a].turn = fire && (op_s1 == OP_TURN) && (axis_s1 == 2'(a));
		assign cmd[a].tick = fire && (op_s1 == OP_TICK);

		tspt_axis u_axis (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[a]),
			.delta   (delta_s1),
			.step    (step_sel),
			.stat    (stat[a]),
			.present (present[a])
		);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			move_started   <= stat[0].started | stat[1].started | stat[2].started;
			busy_mask      <= {stat[2].moving, stat[1].moving, stat[0].moving};
			dir_mask       <= {stat[2].dir, stat[1].dir, stat[0].dir};
			angle_bottom   <= angle_out(present[0]);
			angle_side     <= angle_out(present[1]);
			angle_vertical <= angle_out(present[2]);
		end
	end

endmodule

>>> hdl/tspt_checker.sv
`timescale 1ns / 1ps

module tspt_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic                                 move_started,
	input logic [tspt_pkg::AXES-1:0]            busy_mask,
	input logic signed [tspt_pkg::OUT_W-1:0]    angle_bottom,
	input logic signed [tspt_pkg::OUT_W-1:0]    angle_side,
	input logic signed [tspt_pkg::OUT_W-1:0]    angle_vertical
);
	import tspt_pkg::*;

	// A held result word keeps its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// Input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with result register free");

	// A started move shows as busy in the same word
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_started |-> (busy_mask != '0))
		else $error("move started but no axis busy");

	// With nothing busy, a following word that starts no move cannot change any angle
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (busy_mask == '0) ##1 out_valid && !move_started
		&& (busy_mask == '0) |-> (angle_bottom == $past(angle_bottom))
		&& (angle_side == $past(angle_side)) && (angle_vertical == $past(angle_vertical)))
		else $error("angle moved with all axes idle");

endmodule

bind three_axis_stepper_position_tracker tspt_checker u_tspt_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tspt_pkg::*;

	localparam logic [1:0] AXIS_NONE = 2'd3;
	localparam logic signed [DELTA_W-1:0] DELTA_MAX = 24'sh7FFFFF;
	localparam logic signed [DELTA_W-1:0] DELTA_MIN = 24'sh800000;
	localparam longint ANG_MAX = (longint'(1) << (ANGLE_W - 1)) - 1;
	localparam longint ANG_MIN = -ANG_MAX - 1;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic              started;
		logic [AXES-1:0]   busy;
		logic [AXES-1:0]   dir;
		logic [OUT_W-1:0]  ang_b;
		logic [OUT_W-1:0]  ang_s;
		logic [OUT_W-1:0]  ang_v;
	} status_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       op = OP_TICK;
	logic [1:0]                 axis_sel = AXIS_BOTTOM;
	logic signed [DELTA_W-1:0]  angle_delta = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       move_started;
	logic [AXES-1:0]            busy_mask;
	logic [AXES-1:0]            dir_mask;
	logic signed [OUT_W-1:0]    angle_bottom;
	logic signed [OUT_W-1:0]    angle_side;
	logic signed [OUT_W-1:0]    angle_vertical;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_STEP_BOTTOM;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	// Shadow of the register file
	logic [STEP_W-1:0] step_reg [AXES] = '{STEP_BOTTOM_RST, STEP_SIDE_RST, STEP_VERTICAL_RST};
	logic [GAIN_W-1:0] gain_reg = BOTTOM_GAIN_RST;

	// Tracker state mirror
	longint          tgt_ang [AXES] = '{0, 0, 0};
	longint          cur_ang [AXES] = '{0, 0, 0};
	longint          dist_left [AXES] = '{0, 0, 0};
	longint          steps_run [AXES] = '{0, 0, 0};
	logic [AXES-1:0] dir_bits = '0;
	logic [AXES-1:0] busy_bits = '0;
	logic [AXES-1:0] retarget_bits = '0;

	status_t pending_status [$];
	status_t want_s;
	int      errors = 0;
	int      idle_cycles = 0;
	bit      calm = 1'b0;

	three_axis_stepper_position_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.axis_sel(axis_sel),
		.angle_delta(angle_delta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.move_started(move_started),
		.busy_mask(busy_mask),
		.dir_mask(dir_mask),
		.angle_bottom(angle_bottom),
		.angle_side(angle_side),
		.angle_vertical(angle_vertical),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------- position tracking prediction ----------------

	function automatic longint clamp_angle(longint v);
		if (v > ANG_MAX) begin
			return ANG_MAX;
		end
		if (v < ANG_MIN) begin
			return ANG_MIN;
		end
		return v;
	endfunction

	// Move the target; start a move if idle and more than one step away
	function automatic bit retarget_axis(int ax, longint dl);
		longint gap;
		longint st;
		tgt_ang[ax] = clamp_angle(tgt_ang[ax] + dl);
		if (!busy_bits[ax]) begin
			gap = tgt_ang[ax] - cur_ang[ax];
			st = longint'(step_reg[ax]);
			if (gap > st || gap < -st) begin
				if (gap < 0) begin
					dir_bits[ax] = 1'b1;
					gap = -gap;
				end else begin
					dir_bits[ax] = 1'b0;
				end
				dist_left[ax] = gap;
				steps_run[ax] = 0;
				busy_bits[ax] = 1'b1;
				retarget_bits[ax] = 1'b0;
				return 1'b1;
			end
		end
		retarget_bits[ax] = 1'b1;
		return 1'b0;
	endfunction

	// One step on a busy axis; finish the move on overshoot or a new target, then retry a start
	function automatic void advance_axis(int ax);
		if (busy_bits[ax]) begin
			steps_run[ax] = steps_run[ax] + longint'(step_reg[ax]);
			if (steps_run[ax] > dist_left[ax] || retarget_bits[ax]) begin
				if (!dir_bits[ax]) begin
					cur_ang[ax] = clamp_angle(cur_ang[ax] + steps_run[ax]);
				end else begin
					cur_ang[ax] = clamp_angle(cur_ang[ax] - steps_run[ax]);
				end
				busy_bits[ax] = 1'b0;
				steps_run[ax] = 0;
				void'(retarget_axis(ax, 0));
			end
		end
	endfunction

	function automatic status_t track_word(logic o, logic [1:0] a, logic signed [DELTA_W-1:0] d);
		status_t s;
		longint dl;
		int ax;
		s = '0;
		dl = longint'(d);
		if (o == OP_TURN) begin
			if (a != AXIS_NONE) begin
				if (a == AXIS_BOTTOM) begin
					dl = dl * longint'(gain_reg);
				end
				s.started = retarget_axis(int'(a), dl);
			end
		end else begin
			for (ax = 0; ax < AXES; ax++) begin
				advance_axis(ax);
			end
		end
		s.busy = busy_bits;
		s.dir = dir_bits;
		s.ang_b = cur_ang[int'(AXIS_BOTTOM)][OUT_W-1:0];
		s.ang_s = cur_ang[int'(AXIS_SIDE)][OUT_W-1:0];
		s.ang_v = cur_ang[int'(AXIS_VERTICAL)][OUT_W-1:0];
		return s;
	endfunction

	// ---------------- drivers ----------------

	// Receiver back-pressure
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 8);
	end

	task automatic send_word(logic o, logic [1:0] a, logic signed [DELTA_W-1:0] d);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		axis_sel <= a;
		angle_delta <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_status.push_back(track_word(o, a, d));
	endtask

	// Stop sending and let every outstanding result drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_STEP_BOTTOM: begin
				step_reg[int'(AXIS_BOTTOM)] = data;
			end
			REG_STEP_SIDE: begin
				step_reg[int'(AXIS_SIDE)] = data;
			end
			REG_STEP_VERTICAL: begin
				step_reg[int'(AXIS_VERTICAL)] = data;
			end
			REG_BOTTOM_GAIN: begin
				gain_reg = data[GAIN_W-1:0];
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(logic [STEP_W-1:0] sb, logic [STEP_W-1:0] ss,
			logic [STEP_W-1:0] sv, logic [GAIN_W-1:0] g);
		settle();
		write_reg(REG_STEP_BOTTOM, sb);
		write_reg(REG_STEP_SIDE, ss);
		write_reg(REG_STEP_VERTICAL, sv);
		write_reg(REG_BOTTOM_GAIN, CFG_DATA_W'(g));
	endtask

	task automatic send_tick();
		send_word(OP_TICK, 2'($urandom), DELTA_W'($urandom));
	endtask

	task automatic tick_until_still(logic [1:0] a);
		while (busy_bits[int'(a)]) send_tick();
	endtask

	// Delta sized against the step of the chosen axis
	function automatic logic signed [DELTA_W-1:0] pick_delta(logic [1:0] a);
		longint lim;
		longint mag;
		int r;
		r = $urandom_range(99);
		lim = (a == AXIS_NONE) ? 1000 : longint'(step_reg[int'(a)]);
		if (r >= 90) begin
			return DELTA_W'($urandom);
		end
		lim = (r < 60) ? 4 * lim + 4 : 64 * lim + 64;
		if (lim > longint'(DELTA_MAX)) begin
			lim = longint'(DELTA_MAX);
		end
		mag = longint'($urandom_range(int'(lim)));
		return $urandom_range(1) ? DELTA_W'(-mag) : DELTA_W'(mag);
	endfunction

	// ---------------- checking ----------------

	task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$display("%0t: result word with nothing pending, busy_mask %b", $time, busy_mask);
				errors++;
			end else begin
				want_s = pending_status.pop_front();
				check_field("move_started", OUT_W'(want_s.started), OUT_W'(move_started));
				check_field("busy_mask", OUT_W'(want_s.busy), OUT_W'(busy_mask));
				check_field("dir_mask", OUT_W'(want_s.dir), OUT_W'(dir_mask));
				check_field("angle_bottom", want_s.ang_b, angle_bottom);
				check_field("angle_side", want_s.ang_s, angle_side);
				check_field("angle_vertical", want_s.ang_v, angle_vertical);
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ---------------- tests ----------------

	// Register reset values, each axis, both directions, small-move and unused-axis cases
	task automatic test_power_on_defaults();
		send_word(OP_TICK, AXIS_NONE, DELTA_MAX);
		send_word(OP_TURN, AXIS_SIDE, 5);
		send_word(OP_TURN, AXIS_SIDE, 10);
		send_word(OP_TURN, AXIS_VERTICAL, -1000);
		send_word(OP_TURN, AXIS_BOTTOM, 1);
		send_word(OP_TURN, AXIS_NONE, DELTA_MIN);
		send_word(OP_TURN, AXIS_BOTTOM, 100);
		repeat (3) send_tick();
		// a retarget within one step of the now idle side axis starts no move
		send_word(OP_TURN, AXIS_SIDE, 2);
		send_word(OP_TICK, AXIS_BOTTOM, DELTA_MIN);
		tick_until_still(AXIS_BOTTOM);
		tick_until_still(AXIS_SIDE);
		tick_until_still(AXIS_VERTICAL);
	endtask

	// Zero and largest step sizes, largest gain, target saturation
	task automatic test_register_edges();
		program_regs(16'hFFFF, 16'h0000, 16'h0001, 8'hFF);
		// zero step: only a new target ends the move
		send_word(OP_TURN, AXIS_SIDE, 3);
		repeat (2) send_tick();
		send_word(OP_TURN, AXIS_SIDE, -1);
		send_tick();
		// vertical turns of one with a step of one, then ticks until the axis is still
		send_word(OP_TURN, AXIS_VERTICAL, 1);
		send_word(OP_TURN, AXIS_VERTICAL, 1);
		tick_until_still(AXIS_VERTICAL);
		repeat (2) send_word(OP_TURN, AXIS_BOTTOM, DELTA_MAX);
		repeat (4) send_word(OP_TURN, AXIS_BOTTOM, DELTA_MIN);
		send_word(OP_TURN, AXIS_BOTTOM, 1);
		repeat (3) send_tick();
	endtask

	// Target driven into both saturation limits while the bottom axis keeps moving
	task automatic test_angle_saturation();
		program_regs(16'hFFFF, STEP_SIDE_RST, STEP_VERTICAL_RST, 8'hFF);
		repeat (2) send_word(OP_TURN, AXIS_BOTTOM, DELTA_MAX);
		repeat (8) send_tick();
		repeat (3) send_word(OP_TURN, AXIS_BOTTOM, DELTA_MIN);
		repeat (8) send_tick();
	endtask

	task automatic run_random_phase(logic [STEP_W-1:0] sb, logic [STEP_W-1:0] ss,
			logic [STEP_W-1:0] sv, logic [GAIN_W-1:0] g, int n, bit no_idle, bit drain_mid);
		int k;
		logic [1:0] a;
		program_regs(sb, ss, sv, g);
		calm = no_idle;
		for (k = 0; k < n; k++) begin
			if (drain_mid && k == n / 2) begin
				settle();
			end
			if ($urandom_range(99) < 40) begin
				a = ($urandom_range(99) < 3) ? AXIS_NONE : 2'($urandom_range(2));
				send_word(OP_TURN, a, pick_delta(a));
			end else begin
				send_tick();
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random_mix();
		run_random_phase(STEP_BOTTOM_RST, STEP_SIDE_RST, STEP_VERTICAL_RST, BOTTOM_GAIN_RST,
			250, 1'b0, 1'b0);
		run_random_phase(16'd1, 16'd1, 16'd1, 8'd1, 200, 1'b1, 1'b0);
		run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 200, 1'b0, 1'b1);
		run_random_phase(STEP_W'($urandom_range(1, 600)), STEP_W'($urandom_range(1, 600)),
			STEP_W'($urandom_range(1, 600)), GAIN_W'($urandom_range(1, 255)), 300, 1'b0, 1'b0);
		run_random_phase(STEP_W'($urandom_range(1, 65535)), STEP_W'($urandom_range(1, 65535)),
			STEP_W'($urandom_range(1, 65535)), GAIN_W'($urandom_range(1, 255)), 250, 1'b0, 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_power_on_defaults();
		test_register_edges();
		test_angle_saturation();
		test_random_mix();
		settle();
		repeat (8) @(posedge clk);
		if (pending_status.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, pending_status.size());
			errors++;
		end
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/tspt_pkg.sv
hdl/tspt_axis.sv
hdl/three_axis_stepper_position_tracker.sv
hdl/tspt_checker.sv
tb/sv/tb.sv
